// ===== sv/smsk_pkg.sv =====
package smsk_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_W    = 32;
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W       = 48;
   localparam int ACC2_W      = 2 * SAMPLE_W + ADDR_W + 1;
   localparam int ACC3_W      = 3 * SAMPLE_W + ADDR_W + 2;
   localparam int DIV_W       = ACC3_W;
   localparam int DIVC_W      = $clog2(DIV_W + 1);
   localparam int M3_W        = 64;
   localparam int DEN_W       = 3 * SAMPLE_W;
   localparam int SKEW_STEPS  = M3_W + 3 * FRAC_BITS;
   localparam int SKEWC_W     = $clog2(SKEW_STEPS);
   localparam int SKEW_W      = 24;
   localparam int STATUS_W    = 2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SIGMA_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SKEW_SAT   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd3;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
      logic                    ovf;
   } job_type;

   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } store_wr_type;

endpackage

// ===== sv/sample_moments_skewness.sv =====
// Channel   Ports                                      Handshake
// req       req_sample, req_last                       req_push / req_full
// rsp       rsp_mean, rsp_sigma, rsp_third_moment,     rsp_pop / rsp_empty
//           rsp_skewness, rsp_count, rsp_status
//
// Samples load one item per cycle into a 1024-entry store while req_full is low.
// After the last item of a set, the set goes through a mean division, a pass over
// the store, second- and third-moment divisions, a square root and a skewness
// division; the divider is bit-serial and the store has a single read port.
// Loading of the next set may start once the store pass is over.
// reset is synchronous and clears all control state; the store needs no clearing.
module sample_moments_skewness
   import smsk_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [31:0]         rsp_mean,
   output logic [31:0]                rsp_sigma,
   output logic signed [63:0]         rsp_third_moment,
   output logic signed [SKEW_W-1:0]   rsp_skewness,
   output logic [CNT_W-1:0]           rsp_count,
   output logic [STATUS_W-1:0]        rsp_status
);

   store_wr_type store_wr;
   logic         job_push;
   job_type      job;
   logic         jq_empty;
   logic         jq_pop;
   job_type      jq_head;
   logic         store_busy;
   logic         hold;

   // hold the front while a finished set still owns the store
   assign hold = !jq_empty || store_busy;

   smsk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_last   (req_last),
      .req_full   (req_full),
      .hold       (hold),
      .store_wr   (store_wr),
      .job_push   (job_push),
      .job        (job)
   );

   // queue set descriptors between loading and the computation
   smsk_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (jq_pop),
      .empty    (jq_empty),
      .head     (jq_head)
   );

   smsk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .store_wr         (store_wr),
      .jq_empty         (jq_empty),
      .jq_head          (jq_head),
      .jq_pop           (jq_pop),
      .store_busy       (store_busy),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_mean         (rsp_mean),
      .rsp_sigma        (rsp_sigma),
      .rsp_third_moment (rsp_third_moment),
      .rsp_skewness     (rsp_skewness),
      .rsp_count        (rsp_count),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== sv/smsk_div.sv =====
module smsk_div
   import smsk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [CNT_W-1:0]  divisor,
   output logic              done,
   output logic [DIV_W-1:0]  quotient
);

   logic [DIV_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [DIVC_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;
   logic [CNT_W:0]    shifted;
   logic              fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !start && run_ff && (step_ff == '0);
         if (start) begin
            run_ff  <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            step_ff <= DIVC_W'(DIV_W - 1);
         end else if (run_ff) begin
            // one quotient bit per cycle, restoring
            rem_ff <= fits ? CNT_W'(shifted - {1'b0, divisor}) : shifted[CNT_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            if (step_ff == '0) begin
               run_ff  <= 1'b0;
            end
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/smsk_front.sv =====
module smsk_front
   import smsk_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       req_full,
   input  logic                       hold,
   output store_wr_type               store_wr,
   output logic                       job_push,
   output job_type                    job
);

   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic                    ovf_ff, ovf_in;
   logic                    take;
   logic                    room;

   assign req_full = hold;
   assign take     = req_push && !hold;
   assign room     = cnt_ff < CNT_W'(MAX_SAMPLES);

   always_comb begin
      cnt_in = cnt_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      if (room) begin
         cnt_in = cnt_ff + 1'b1;
         sum_in = sum_ff + SUM_W'(req_sample);
      end else begin
         ovf_in = 1'b1;
      end
   end

   assign store_wr.we   = take && room;
   assign store_wr.addr = cnt_ff[ADDR_W-1:0];
   assign store_wr.data = req_sample;
   assign job_push      = take && req_last;
   assign job.sum       = sum_in;
   assign job.count     = cnt_in;
   assign job.ovf       = ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (take) begin
         if (req_last) begin
            // hand the set over, start a fresh one
            cnt_ff <= '0;
            sum_ff <= '0;
            ovf_ff <= 1'b0;
         end else begin
            cnt_ff <= cnt_in;
            sum_ff <= sum_in;
            ovf_ff <= ovf_in;
         end
      end
   end

endmodule

// ===== sv/smsk_jobq.sv =====
module smsk_jobq
   import smsk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    empty,
   output job_type head
);

   job_type    slot_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] fill_ff;

   assign empty = fill_ff == 2'd0;
   assign head  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// ===== sv/smsk_back.sv =====
module smsk_back
   import smsk_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  store_wr_type               store_wr,
   input  logic                       jq_empty,
   input  job_type                    jq_head,
   output logic                       jq_pop,
   output logic                       store_busy,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [31:0]         rsp_mean,
   output logic [31:0]                rsp_sigma,
   output logic signed [63:0]         rsp_third_moment,
   output logic signed [SKEW_W-1:0]   rsp_skewness,
   output logic [CNT_W-1:0]           rsp_count,
   output logic [STATUS_W-1:0]        rsp_status
);

   typedef enum logic [3:0] {
      IDLE, MEAN, PASS, DRAIN, DIV2, DIV3, SQRT, CUBE1, CUBE2, CUBE3, SKEW, FIN
   } state_type;

   state_type state_ff;

   logic [SAMPLE_W-1:0] store [MAX_SAMPLES];
   logic [SAMPLE_W-1:0] rdata_ff;

   job_type                    job_ff;
   logic signed [SAMPLE_W-1:0] mean_ff;
   logic [CNT_W-1:0]           idx_ff;
   logic                       div_start_ff;
   logic [DIV_W-1:0]           div_arg_ff;
   logic                       div_done;
   logic [DIV_W-1:0]           div_q;
   logic [63:0]                m2_ff;
   logic [M3_W-1:0]            m3_ff;
   logic                       neg3_ff;
   logic [63:0]                sq_r_ff, sq_v_ff, sq_bit_ff;
   logic [63:0]                sq_try, sq_r_in;
   logic [31:0]                sigma_ff;
   logic [63:0]                sig2_ff, dlo_ff, dhi_ff;
   logic [DEN_W-1:0]           den_ff;
   logic [DEN_W:0]             rem_ff, rem_sh;
   logic [M3_W-1:0]            num_ff;
   logic [25:0]                q_ff, q_in;
   logic                       big_ff;
   logic [SKEWC_W-1:0]         k_ff;
   logic                       fit;

   // second pass pipeline
   logic                       v1_ff, v2_ff, v3_ff, v4_ff;
   logic                       n2_ff, n3_ff, n4_ff;
   logic [31:0]                ad2_ff, ad3_ff;
   logic [63:0]                sq3_ff, sq4_ff, plo_ff, phi_ff;
   logic [ACC2_W-1:0]          acc2_ff;
   logic signed [ACC3_W-1:0]   acc3_ff;
   logic signed [SAMPLE_W+1:0] diff;
   logic [DEN_W-1:0]           cube;
   logic                       acc_clr;
   logic                       rd_en;

   // result register
   logic                       out_valid_ff;
   logic [ACC3_W-1:0]          acc3_mag;
   logic [DIV_W-1:0]           mag_sh;
   logic [M3_W-1:0]            m3_lim, m3_in;
   logic [SKEW_W-1:0]          skew_mag;
   logic signed [SKEW_W-1:0]   skew_out;
   logic [STATUS_W-1:0]        status_out;

   smsk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_arg_ff),
      .divisor  (job_ff.count),
      .done     (div_done),
      .quotient (div_q)
   );

   assign jq_pop     = (state_ff == IDLE) && !jq_empty;
   assign store_busy = (state_ff == MEAN) || (state_ff == PASS) || (state_ff == DRAIN);
   assign acc_clr    = state_ff == MEAN;
   assign rd_en      = state_ff == PASS;

   always_ff @(posedge clock) begin
      if (store_wr.we) store[store_wr.addr] <= store_wr.data;
      if (rd_en)       rdata_ff <= store[idx_ff[ADDR_W-1:0]];
   end

   assign diff = (SAMPLE_W+2)'($signed(rdata_ff)) - (SAMPLE_W+2)'(mean_ff);
   assign cube = {phi_ff, 32'b0} + DEN_W'(plo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      n2_ff  <= diff[SAMPLE_W+1];
      ad2_ff <= diff[SAMPLE_W+1] ? 32'(-diff) : diff[31:0];
      n3_ff  <= n2_ff;
      ad3_ff <= ad2_ff;
      sq3_ff <= ad2_ff * ad2_ff;
      n4_ff  <= n3_ff;
      sq4_ff <= sq3_ff;
      plo_ff <= sq3_ff[31:0] * ad3_ff;
      phi_ff <= sq3_ff[63:32] * ad3_ff;
      if (acc_clr) begin
         acc2_ff <= '0;
         acc3_ff <= '0;
      end else if (v4_ff) begin
         acc2_ff <= acc2_ff + ACC2_W'(sq4_ff);
         acc3_ff <= n4_ff ? acc3_ff - $signed(ACC3_W'(cube))
                          : acc3_ff + $signed(ACC3_W'(cube));
      end
   end

   assign acc3_mag = acc3_ff[ACC3_W-1] ? ACC3_W'(-acc3_ff) : ACC3_W'(acc3_ff);
   assign mag_sh   = div_q >> (2 * FRAC_BITS);
   assign m3_lim   = neg3_ff ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
   assign m3_in    = ((|mag_sh[DIV_W-1:M3_W]) || (mag_sh[M3_W-1:0] > m3_lim))
                     ? m3_lim : mag_sh[M3_W-1:0];

   // one digit pair of the square root per cycle
   assign sq_try  = sq_r_ff + sq_bit_ff;
   assign sq_r_in = (sq_v_ff >= sq_try) ? (sq_r_ff >> 1) + sq_bit_ff : sq_r_ff >> 1;

   // skewness long division, quotient kept only up to its saturation point
   assign rem_sh = {rem_ff[DEN_W-1:0], num_ff[M3_W-1]};
   assign fit    = rem_sh >= {1'b0, den_ff};
   assign q_in   = {q_ff[24:0], fit};

   always_comb begin
      skew_mag   = '0;
      skew_out   = '0;
      status_out = ST_OK;
      if (sigma_ff == '0) begin
         status_out = ST_SIGMA_ZERO;
      end else if (neg3_ff && m3_ff != '0) begin
         if (big_ff || q_ff > 26'h0800000) begin
            skew_mag   = {1'b1, 23'b0};
            status_out = ST_SKEW_SAT;
         end else begin
            skew_mag = q_ff[SKEW_W-1:0];
         end
         skew_out = $signed(-skew_mag);
      end else begin
         if (big_ff || q_ff > 26'h07FFFFF) begin
            skew_mag   = {1'b0, {23{1'b1}}};
            status_out = ST_SKEW_SAT;
         end else begin
            skew_mag = q_ff[SKEW_W-1:0];
         end
         skew_out = $signed(skew_mag);
      end
      if (job_ff.ovf) status_out = ST_OVERFLOW;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         div_start_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // kick the divider for the mean, the second moment and the third moment
         div_start_ff <= ((state_ff == IDLE) && !jq_empty)
                         || ((state_ff == DRAIN) && !(v1_ff || v2_ff || v3_ff || v4_ff))
                         || ((state_ff == DIV2) && div_done);
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (!jq_empty) begin
                  job_ff       <= jq_head;
                  div_arg_ff   <= DIV_W'(jq_head.sum[SUM_W-1] ? -jq_head.sum : jq_head.sum);
                  state_ff     <= MEAN;
               end
            end
            MEAN: begin
               if (div_done) begin
                  mean_ff  <= job_ff.sum[SUM_W-1] ? -div_q[31:0] : div_q[31:0];
                  idx_ff   <= '0;
                  state_ff <= PASS;
               end
            end
            PASS: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == job_ff.count - 1'b1) state_ff <= DRAIN;
            end
            DRAIN: begin
               if (!(v1_ff || v2_ff || v3_ff || v4_ff)) begin
                  div_arg_ff   <= DIV_W'(acc2_ff);
                  state_ff     <= DIV2;
               end
            end
            DIV2: begin
               if (div_done) begin
                  m2_ff        <= div_q[63:0];
                  neg3_ff      <= acc3_ff[ACC3_W-1];
                  div_arg_ff   <= acc3_mag;
                  state_ff     <= DIV3;
               end
            end
            DIV3: begin
               if (div_done) begin
                  m3_ff     <= m3_in;
                  sq_r_ff   <= '0;
                  sq_v_ff   <= m2_ff;
                  sq_bit_ff <= 64'h4000_0000_0000_0000;
                  state_ff  <= SQRT;
               end
            end
            SQRT: begin
               if (sq_v_ff >= sq_try) sq_v_ff <= sq_v_ff - sq_try;
               sq_r_ff   <= sq_r_in;
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff[0]) begin
                  sigma_ff <= sq_r_in[31:0];
                  state_ff <= CUBE1;
               end
            end
            CUBE1: begin
               sig2_ff  <= sigma_ff * sigma_ff;
               state_ff <= CUBE2;
            end
            CUBE2: begin
               dlo_ff   <= sig2_ff[31:0] * sigma_ff;
               dhi_ff   <= sig2_ff[63:32] * sigma_ff;
               state_ff <= CUBE3;
            end
            CUBE3: begin
               den_ff   <= {dhi_ff, 32'b0} + DEN_W'(dlo_ff);
               rem_ff   <= '0;
               num_ff   <= m3_ff;
               q_ff     <= '0;
               big_ff   <= 1'b0;
               k_ff     <= SKEWC_W'(SKEW_STEPS - 1);
               state_ff <= (sigma_ff == '0) ? FIN : SKEW;
            end
            SKEW: begin
               rem_ff <= fit ? rem_sh - {1'b0, den_ff} : rem_sh;
               num_ff <= {num_ff[M3_W-2:0], 1'b0};
               q_ff   <= q_in;
               if (q_in > 26'h1000000) big_ff <= 1'b1;
               k_ff   <= k_ff - 1'b1;
               if (k_ff == '0) state_ff <= FIN;
            end
            FIN: begin
               if (!out_valid_ff) begin
                  out_valid_ff     <= 1'b1;
                  rsp_mean         <= mean_ff;
                  rsp_sigma        <= sigma_ff;
                  rsp_third_moment <= neg3_ff ? $signed(-m3_ff) : $signed(m3_ff);
                  rsp_skewness     <= skew_out;
                  rsp_count        <= job_ff.count;
                  rsp_status       <= status_out;
                  state_ff         <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule
